// ===== hw/rtl/mvm_pkg.sv =====
package mvm_pkg;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_MATRIX = 1'b1;

  localparam logic CFG_NUM_COLS = 1'b0;
  localparam logic CFG_NUM_ROWS = 1'b1;

  localparam logic [10:0] NUM_COLS_RESET = 11'd1024;
  localparam logic [15:0] NUM_ROWS_RESET = 16'd1024;

  localparam int ACC_BITS  = 48;
  localparam int FRAC_BITS = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  typedef struct packed {
    logic               op;
    logic [9:0]         vec_index;
    logic signed [31:0] data_value;
    logic signed [31:0] prior_sum;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] row_sum;
    logic [15:0]        row_number;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic [10:0] num_cols;
    logic [15:0] num_rows;
  } cfg_t;

  // one matrix element on its way to the multiply-accumulate unit
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] a;
    logic [31:0] prior;
    logic        first;
    logic        last;
    logic [15:0] row;
  } mvm_task_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hw/rtl/mvm_front.sv =====
module mvm_front import mvm_pkg::*; #(
  parameter int MAX_COLS   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      push,
  output mvm_task_t task_out,
  input  q_status_t q_status
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W = $clog2(MAX_COLS + 1);

  logic [VALUE_BITS-1:0] mem [MAX_COLS];
  logic [VALUE_BITS-1:0] rd_r;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [15:0]      row_r, row_nxt;

  logic        stage_valid_r, stage_valid_nxt;
  logic [31:0] a_r, prior_r;
  logic        first_r, last_r;
  logic [15:0] srow_r;

  logic             accept, is_mat, is_load;
  logic [31:0]      idx_ext;
  logic             idx_ok;
  logic [CNT_W-1:0] cols_eff, col_inc;
  logic             last_c, first_c;
  logic [16:0]      rows_eff, row_inc;

  assign in_stall = stage_valid_r && q_status.full;
  assign accept   = in_valid && !in_stall;
  assign is_mat   = accept && (in_item.op == OP_MATRIX);
  assign is_load  = accept && (in_item.op == OP_LOAD);

  assign idx_ext = 32'(in_item.vec_index);
  assign idx_ok  = idx_ext < 32'(MAX_COLS);

  // zero columns act as one, more than the store holds act as the store depth
  always_comb begin
    if (cfg.num_cols == 11'd0) begin
      cols_eff = CNT_W'(1);
    end else if (32'(cfg.num_cols) > 32'(MAX_COLS)) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cols_eff = CNT_W'(cfg.num_cols);
    end
  end

  assign col_inc  = CNT_W'(col_r) + CNT_W'(1);
  assign last_c   = col_inc >= cols_eff;
  assign first_c  = (col_r == '0);
  assign rows_eff = (cfg.num_rows == 16'd0) ? 17'h10000 : {1'b0, cfg.num_rows};
  assign row_inc  = {1'b0, row_r} + 17'd1;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (is_mat) begin
      if (last_c) begin
        col_nxt = '0;
        row_nxt = (row_inc >= rows_eff) ? 16'd0 : row_inc[15:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (accept) begin
      stage_valid_nxt = is_mat;
    end else if (push) begin
      stage_valid_nxt = 1'b0;
    end
  end

  assign push = stage_valid_r && !q_status.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r         <= '0;
      row_r         <= '0;
      stage_valid_r <= 1'b0;
    end else begin
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_mat) begin
      a_r     <= in_item.data_value;
      prior_r <= in_item.prior_sum;
      first_r <= first_c;
      last_r  <= last_c;
      srow_r  <= row_r;
    end
  end

  // vector store: load writes, matrix element reads its column
  always_ff @(posedge clk) begin
    if (is_load && idx_ok) begin
      mem[idx_ext[COL_W-1:0]] <= in_item.data_value[VALUE_BITS-1:0];
    end
    if (is_mat) begin
      rd_r <= mem[col_r];
    end
  end

  always_comb begin
    task_out.x     = 32'(rd_r);
    task_out.a     = a_r;
    task_out.prior = prior_r;
    task_out.first = first_r;
    task_out.last  = last_r;
    task_out.row   = srow_r;
  end

endmodule

// ===== hw/rtl/mvm_queue.sv =====
module mvm_queue import mvm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mvm_task_t push_data,
  input  logic      pop,
  output mvm_task_t pop_data,
  output q_status_t q_status
);

  mvm_task_t slots [QUEUE_DEPTH];

  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_PTR_W:0]   count_r, count_nxt;

  assign q_status.full  = (count_r == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign q_status.empty = (count_r == '0);
  assign pop_data       = slots[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QUEUE_PTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QUEUE_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/mvm_back.sv =====
module mvm_back import mvm_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  mvm_task_t task_in,
  input  q_status_t q_status,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam longint SAT_HI_L = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
  localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'(SAT_HI_L);
  localparam logic signed [ACC_BITS-1:0] SAT_LO = -SAT_HI - ACC_BITS'(1);

  logic adv;

  // multiply stage
  logic                           m_valid_r;
  logic signed [2*VALUE_BITS-1:0] prod_r;
  logic signed [VALUE_BITS-1:0]   m_prior_r;
  logic                           m_first_r, m_last_r;
  logic [15:0]                    m_row_r;

  // accumulate stage
  logic signed [ACC_BITS-1:0] acc_r, acc_nxt;
  logic                       sum_valid_r;
  logic [15:0]                sum_row_r;

  // output register
  logic      out_valid_r;
  out_item_t out_item_r;

  logic signed [VALUE_BITS-1:0] a_v, x_v;
  logic signed [63:0]           p64, rnd;
  logic signed [ACC_BITS-1:0]   term, prior_ext, base;
  logic signed [ACC_BITS-1:0]   clip;
  logic                         sat;

  assign adv = !(out_valid_r && out_stall);
  assign pop = adv && !q_status.empty;

  assign a_v = task_in.a[VALUE_BITS-1:0];
  assign x_v = task_in.x[VALUE_BITS-1:0];

  // round half up from Q32.32 to Q32.16
  assign p64       = 64'(prod_r);
  assign rnd       = p64 + (64'sd1 <<< (FRAC_BITS - 1));
  assign term      = rnd[63:FRAC_BITS];
  assign prior_ext = ACC_BITS'(m_prior_r);
  assign base      = m_first_r ? prior_ext : acc_r;
  assign acc_nxt   = base + term;

  always_comb begin
    clip = acc_r;
    sat  = 1'b0;
    if (acc_r > SAT_HI) begin
      clip = SAT_HI;
      sat  = 1'b1;
    end else if (acc_r < SAT_LO) begin
      clip = SAT_LO;
      sat  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      sum_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else if (adv) begin
      m_valid_r   <= pop;
      sum_valid_r <= m_valid_r && m_last_r;
      out_valid_r <= sum_valid_r;
      if (m_valid_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (pop) begin
        prod_r    <= a_v * x_v;
        m_prior_r <= task_in.prior[VALUE_BITS-1:0];
        m_first_r <= task_in.first;
        m_last_r  <= task_in.last;
        m_row_r   <= task_in.row;
      end
      if (m_valid_r) begin
        sum_row_r <= m_row_r;
      end
      if (sum_valid_r) begin
        out_item_r.row_sum    <= 32'(clip);
        out_item_r.row_number <= sum_row_r;
        out_item_r.saturated  <= sat;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== hw/rtl/matrix_vector_mac.sv =====
// Path: a row's last element is accepted and its vector store read happens at
// the accepting edge, then it passes the queue, multiply, accumulate and the
// saturate/output register, where the row's result becomes valid.
// Throughput: one item per cycle while in_stall is low; the single MAC unit
// and the one-port vector store each handle one element per cycle.
// Reset: synchronous active-low rst_n clears counters, queue, valids and sets
// num_cols and num_rows to 1024; the vector store is not cleared.
module matrix_vector_mac import mvm_pkg::*; #(
  parameter int MAX_COLS   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t      cfg_r;
  logic      push, pop;
  mvm_task_t push_data, pop_data;
  q_status_t q_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_cols <= NUM_COLS_RESET;
      cfg_r.num_rows <= NUM_ROWS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_NUM_COLS: cfg_r.num_cols <= cfg_wdata[10:0];
        CFG_NUM_ROWS: cfg_r.num_rows <= cfg_wdata;
        default:      cfg_r <= cfg_r;
      endcase
    end
  end

  mvm_front #(
    .MAX_COLS  (MAX_COLS),
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item (in_item),
    .push    (push),
    .task_out(push_data),
    .q_status(q_status)
  );

  mvm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .q_status (q_status)
  );

  mvm_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .task_in  (pop_data),
    .q_status (q_status),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_status.full)
    else $error("input stalled while queue has room");

  a_reset_out_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
